// File: rtl/cle_pkg.sv
// shared types, codes and defaults for the cursor list engine
`timescale 1ns / 1ps

package cle_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int SCAN_GROUP    = 8;

    localparam logic [6:0] CAP_RESET = 7'd64;

    // request codes
    localparam logic [3:0] FN_INSERT  = 4'd0;
    localparam logic [3:0] FN_REMOVE  = 4'd1;
    localparam logic [3:0] FN_REPLACE = 4'd2;
    localparam logic [3:0] FN_CLEAR   = 4'd3;
    localparam logic [3:0] FN_FIRST   = 4'd4;
    localparam logic [3:0] FN_LAST    = 4'd5;
    localparam logic [3:0] FN_NEXT    = 4'd6;
    localparam logic [3:0] FN_PRIOR   = 4'd7;
    localparam logic [3:0] FN_READ    = 4'd8;
    localparam logic [3:0] FN_MOVE_TO = 4'd9;
    localparam logic [3:0] FN_FIND    = 4'd10;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_RANGE    = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
        logic rep;
        logic find;
    } cell_cmd_t;

    // scanner report
    typedef struct packed {
        logic done;
        logic found;
    } scan_res_t;

    // one result word as queued for the output
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [5:0]  cursor_index;
        logic [6:0]  entry_count;
    } result_t;

endpackage

// File: rtl/cursor_list_engine.sv
// top level: ordered list with a cursor, built as a chain of entry cells
`timescale 1ns / 1ps
// results: insert, remove, replace, clear and cursor moves give their result word in the
//   cycle after acceptance; read passes the S_READ state and its registered cursor-entry
//   select; find passes the cell match registers and the scanner (8 match bits per cycle)
// throughput: one request at a time, a new word is taken as soon as the engine is idle
//   and the 2-word output queue has room, so requests without read or scan run back to back
// reset (aresetn, synchronous, active low): empties the list, cursor to 0, capacity to 64,
//   output queue emptied; entry words are not cleared and are never read before written

module cursor_list_engine #(
    parameter int DEPTH     = cle_pkg::DEPTH_DEF,
    parameter int WORD_BITS = cle_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // capacity register
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [31:0] s_data_value,
    input  logic [5:0]  s_position,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_read_value,
    output logic [5:0]  m_cursor_index,
    output logic [6:0]  m_entry_count
);
    import cle_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;   // compare width vs 7-bit ports

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [6:0]       capacity_reg;
    logic [WORD_BITS-1:0] rd_reg;

    logic                 accept;
    logic [WORD_BITS-1:0] din;
    logic                 empty, full;
    logic [CNT_W-1:0]     cur_ext;
    logic [CNT_W-1:0]     cnt_dec;
    logic [2:0]           stat;
    logic                 go_read, go_scan;
    cell_cmd_t            cmd;

    // the cell chain
    logic [WORD_BITS-1:0] words   [DEPTH];
    logic [WORD_BITS-1:0] left_w  [DEPTH];
    logic [WORD_BITS-1:0] right_w [DEPTH];
    logic [DEPTH-1:0]     match_vec;

    // scanner
    scan_res_t        scan_res;
    logic [IDX_W-1:0] scan_idx;

    // output queue, two words deep
    result_t     q_mem [2];
    logic        q_wr_reg, q_rd_reg;
    logic [1:0]  q_fill_reg;
    logic        push, pop;
    result_t     push_word;

    assign accept  = s_valid && s_ready;
    assign din     = WORD_BITS'(s_data_value);
    assign empty   = (count_reg == '0);
    // capacity limited to DEPTH; capacity of zero means always full
    assign full    = (CW'(count_reg) >= CW'(capacity_reg)) || (count_reg == CNT_W'(DEPTH));
    assign cur_ext = CNT_W'(cursor_reg);
    assign cnt_dec = count_reg - CNT_W'(1);

    // combinational request decode
    always_comb begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        stat        = STAT_OK;
        go_read     = 1'b0;
        go_scan     = 1'b0;
        case (s_func)
            FN_INSERT: begin
                if (full) begin
                    stat = STAT_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_REMOVE: begin
                if (empty) begin
                    stat = STAT_EMPTY;
                end else begin
                    count_next = cnt_dec;
                    // removing the tail pulls the cursor back onto the new tail
                    if (cnt_dec == '0) begin
                        cursor_next = '0;
                    end else if (cur_ext >= cnt_dec) begin
                        cursor_next = IDX_W'(cnt_dec - CNT_W'(1));
                    end
                end
            end
            FN_REPLACE: begin
                if (empty) begin
                    stat = STAT_EMPTY;
                end
            end
            FN_CLEAR: begin
                count_next  = '0;
                cursor_next = '0;
            end
            FN_FIRST: begin
                if (empty) begin
                    stat = STAT_EMPTY;
                end else begin
                    cursor_next = '0;
                end
            end
            FN_LAST: begin
                if (empty) begin
                    stat = STAT_EMPTY;
                end else begin
                    cursor_next = IDX_W'(cnt_dec);
                end
            end
            FN_NEXT: begin
                if (empty || (cur_ext + CNT_W'(1) >= count_reg)) begin
                    stat = STAT_NOTFOUND;
                end else begin
                    cursor_next = cursor_reg + IDX_W'(1);
                end
            end
            FN_PRIOR: begin
                if (empty || cursor_reg == '0) begin
                    stat = STAT_NOTFOUND;
                end else begin
                    cursor_next = cursor_reg - IDX_W'(1);
                end
            end
            FN_READ: begin
                if (empty) begin
                    stat = STAT_EMPTY;
                end else begin
                    go_read = 1'b1;
                end
            end
            FN_MOVE_TO: begin
                if (CW'(s_position) >= CW'(count_reg)) begin
                    stat = STAT_RANGE;
                end else begin
                    cursor_next = IDX_W'(s_position);
                end
            end
            FN_FIND: begin
                go_scan = 1'b1;
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
    end

    // cell broadcast
    assign cmd.ins  = accept && (s_func == FN_INSERT) && !full;
    assign cmd.rem  = accept && (s_func == FN_REMOVE) && !empty;
    assign cmd.rep  = accept && (s_func == FN_REPLACE) && !empty;
    assign cmd.find = accept && go_scan;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_w[i] = '0;
        end else begin : g_body
            assign left_w[i] = words[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_w[i] = '0;
        end else begin : g_inner
            assign right_w[i] = words[i+1];
        end

        cle_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cursor     (cursor_reg),
            .count      (count_reg),
            .din        (din),
            .left_word  (left_w[i]),
            .right_word (right_w[i]),
            .word       (words[i]),
            .match      (match_vec[i])
        );
    end

    cle_scan #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.find),
        .match   (match_vec),
        .res     (scan_res),
        .index   (scan_idx)
    );

    // result word selection: immediate, after read, or after scan
    always_comb begin
        push      = 1'b0;
        push_word = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (go_read) begin
                        state_next = S_READ;
                    end else if (go_scan) begin
                        state_next = S_SCAN;
                    end else begin
                        push                   = 1'b1;
                        push_word.status       = stat;
                        push_word.cursor_index = 6'(cursor_next);
                        push_word.entry_count  = 7'(count_next);
                    end
                end
            end
            S_READ: begin
                push                   = 1'b1;
                push_word.status       = STAT_OK;
                push_word.read_value   = 32'(rd_reg);
                push_word.cursor_index = 6'(cursor_reg);
                push_word.entry_count  = 7'(count_reg);
                state_next             = S_IDLE;
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    push                   = 1'b1;
                    push_word.status       = scan_res.found ? STAT_OK : STAT_NOTFOUND;
                    push_word.cursor_index = scan_res.found ? 6'(scan_idx) : 6'(cursor_reg);
                    push_word.entry_count  = 7'(count_reg);
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            capacity_reg <= CAP_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                capacity_reg <= cfg_wdata;
            end
            if (accept) begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end else if (state_reg == S_SCAN && scan_res.found) begin
                cursor_reg <= scan_idx;
            end
        end
    end

    // registered select of the cursor entry
    always_ff @(posedge aclk) begin
        if (accept && go_read) begin
            rd_reg <= words[cursor_reg];
        end
    end

    // output queue
    assign pop = (q_fill_reg != 2'd0) && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[q_wr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg   <= 1'b0;
            q_rd_reg   <= 1'b0;
            q_fill_reg <= 2'd0;
        end else begin
            if (push) begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (pop) begin
                q_rd_reg <= ~q_rd_reg;
            end
            q_fill_reg <= q_fill_reg + 2'(push) - 2'(pop);
        end
    end

    assign s_ready        = (state_reg == S_IDLE) && (q_fill_reg != 2'd2);
    assign m_valid        = (q_fill_reg != 2'd0);
    assign m_status       = q_mem[q_rd_reg].status;
    assign m_read_value   = q_mem[q_rd_reg].read_value;
    assign m_cursor_index = q_mem[q_rd_reg].cursor_index;
    assign m_entry_count  = q_mem[q_rd_reg].entry_count;

    // cursor stays on a held entry, and at 0 for an empty list
    a_cursor_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (cur_ext < count_reg))
        else $error("cursor beyond last entry");

    a_cursor_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (cursor_reg == '0))
        else $error("cursor not at zero on empty list");

    // an insert that fits grows the list by exactly one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FN_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // the queue never receives a word it has no room for
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_fill_reg != 2'd2 || pop))
        else $error("output queue overflow");

endmodule

// File: rtl/cle_cell.sv
// one list entry: holds a word, shifts with its neighbors, compares for find
`timescale 1ns / 1ps

module cle_cell #(
    parameter int WORD_BITS = cle_pkg::WORD_BITS_DEF,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                  aclk,
    input  cle_pkg::cell_cmd_t    cmd,
    input  logic [IDX_W-1:0]      cursor,
    input  logic [CNT_W-1:0]      count,
    input  logic [WORD_BITS-1:0]  din,
    input  logic [WORD_BITS-1:0]  left_word,
    input  logic [WORD_BITS-1:0]  right_word,
    output logic [WORD_BITS-1:0]  word,
    output logic                  match
);
    import cle_pkg::*;

    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 match_reg, match_next;
    logic [CNT_W-1:0]     cur_ext;

    assign cur_ext = CNT_W'(cursor);

    always_comb begin
        word_next  = word_reg;
        match_next = match_reg;
        if (cmd.ins) begin
            if (POS == cur_ext) begin
                word_next = din;
            end else if (POS > cur_ext && POS <= count) begin
                word_next = left_word;
            end
        end else if (cmd.rem) begin
            if (POS >= cur_ext && POS_NEXT < count) begin
                word_next = right_word;
            end
        end else if (cmd.rep && POS == cur_ext) begin
            word_next = din;
        end
        if (cmd.find) begin
            match_next = (word_reg == din) && (POS < count);
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

// File: rtl/cle_scan.sv
// first-match scanner over the cell match bits, one group of bits per cycle
`timescale 1ns / 1ps

module cle_scan #(
    parameter int DEPTH = cle_pkg::DEPTH_DEF,
    parameter int IDX_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DEPTH-1:0]    match,
    output cle_pkg::scan_res_t  res,
    output logic [IDX_W-1:0]    index
);
    import cle_pkg::*;

    localparam int GRP   = SCAN_GROUP;
    localparam int NG    = (DEPTH + GRP - 1) / GRP;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int LW    = $clog2(GRP);
    localparam int PAD_W = NG * GRP;

    logic [PAD_W-1:0] padded;
    logic [GRP-1:0]   grp_bits;
    logic [GW-1:0]    grp_reg;
    logic             busy_reg;
    logic [LW-1:0]    lo;
    logic             hit;
    logic             last;
    logic [GW+LW-1:0] idx_full;

    assign padded   = PAD_W'(match);
    assign grp_bits = padded[grp_reg*GRP +: GRP];
    assign hit      = |grp_bits;
    assign last     = (grp_reg == GW'(NG - 1));

    // lowest set bit of the group
    always_comb begin
        lo = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (grp_bits[k]) begin
                lo = LW'(k);
            end
        end
    end

    assign idx_full  = {grp_reg, lo};
    assign index     = IDX_W'(idx_full);
    assign res.done  = busy_reg && (hit || last);
    assign res.found = busy_reg && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            grp_reg  <= '0;
        end else if (res.done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            grp_reg  <= grp_reg + GW'(1);
        end
    end

endmodule
